/* design/assert_macros.svh */
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define GLM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define GLM_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* design/glm_pkg.sv */
// shared types and constants of the grid local minimum detector
package glm_pkg;

    // default grid limits and register reset values
    localparam int         GLM_MAX_COLS = 128;
    localparam int         GLM_MAX_ROWS = 128;
    localparam logic [7:0] GRID_DEFAULT = 8'd100;

    // value limits of the height map and the risk sum
    localparam logic [3:0]  HEIGHT_MAX = 4'd9;
    localparam logic [17:0] RISK_MAX   = 18'h3ffff;

    // register index, taken from paddr bit 2
    typedef enum logic {
        REG_GRID_COLS = 1'b0,
        REG_GRID_ROWS = 1'b1
    } t_reg_idx;

    // position of an item in the frame, row and column masked to 7 bits
    typedef struct packed {
        logic [6:0] row;
        logic [6:0] col;
        logic       row_ge1;
        logic       row_ge2;
        logic       col_ge1;
        logic       col_ge2;
        logic       row_last;
        logic       col_last;
    } t_pos;

    // one detected low cell
    typedef struct packed {
        logic [6:0]  row;
        logic [6:0]  col;
        logic [3:0]  height;
        logic [17:0] total;
    } t_result;

    // all low cells released by one item, packed from slot 0
    typedef struct packed {
        logic [1:0]        num;
        t_result [2:0]     slot;
    } t_result_set;

endpackage

/* design/glm_line_buf.sv */
// two-row line buffer: one word per column holding the row above and the row two above
module glm_line_buf #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [ADDR_W-1:0] i_next_addr,
    input  logic              i_wr_en,
    input  logic [7:0]        i_wr_data,
    output logic [7:0]        o_cur_word,
    output logic [7:0]        o_next_word
);

    // word layout: [7:4] two rows above, [3:0] row above
    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_cur_word;
    logic [7:0]        r_next_word;
    logic [ADDR_W-1:0] r_wr_addr;

    // write back the item read last, on its own column
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_addr] <= i_wr_data;
        end
    end

    // registered reads with bypass of the write done at the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_wr_addr   <= i_addr;
            r_cur_word  <= (i_wr_en && (r_wr_addr == i_addr)) ? i_wr_data : r_mem[i_addr];
            r_next_word <= (i_wr_en && (r_wr_addr == i_next_addr)) ? i_wr_data
                                                                   : r_mem[i_next_addr];
        end
    end

    assign o_cur_word  = r_cur_word;
    assign o_next_word = r_next_word;

endmodule

/* design/glm_eval.sv */
// judge stage: neighbor compares, result packing and the running risk sum
module glm_eval (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_load,
    input  logic [3:0]           i_height,
    input  glm_pkg::t_pos        i_pos,
    input  logic [7:0]           i_cur_word,
    input  logic [7:0]           i_next_word,
    input  logic                 i_q_free,
    output logic                 o_ready,
    output logic                 o_advance,
    output logic [7:0]           o_wr_data,
    output logic                 o_q_load,
    output glm_pkg::t_result_set o_set
);
    import glm_pkg::*;

    logic        r_valid;
    logic [3:0]  r_height;
    t_pos        r_pos;
    logic [3:0]  r_left0;
    logic [3:0]  r_left1;
    logic [3:0]  r_left_above;
    logic [17:0] r_risk_sum;

    logic [3:0]  above;
    logic [3:0]  two_above;
    logic [3:0]  above_right;
    logic        f1, f2, f3;
    t_result     e1, e2, e3;
    logic [17:0] t1, t2, t3;
    t_result_set set;

    function automatic logic [17:0] add_risk(input logic [17:0] sum, input logic [3:0] h);
        logic [18:0] s;
        s = {1'b0, sum} + 19'(h + 4'd1);
        return s[18] ? RISK_MAX : s[17:0];
    endfunction

    assign above       = i_cur_word[3:0];
    assign two_above   = i_cur_word[7:4];
    assign above_right = i_next_word[3:0];

    // candidate in the row above, its lower neighbor is this item
    assign f1 = r_pos.row_ge1 && (r_height > above)
             && !(r_pos.row_ge2 && (two_above <= above))
             && !(r_pos.col_ge1 && (r_left_above <= above))
             && !(!r_pos.col_last && (above_right <= above));

    // left neighbor in the last row, its right neighbor is this item
    assign f2 = r_pos.row_last && r_pos.col_ge1 && (r_height > r_left0)
             && !(r_pos.col_ge2 && (r_left1 <= r_left0))
             && !(r_pos.row_ge1 && (r_left_above <= r_left0));

    // final cell of the frame
    assign f3 = r_pos.row_last && r_pos.col_last
             && !(r_pos.col_ge1 && (r_left0 <= r_height))
             && !(r_pos.row_ge1 && (above <= r_height));

    // running risk total in raster order of the candidates
    assign t1 = f1 ? add_risk(r_risk_sum, above) : r_risk_sum;
    assign t2 = f2 ? add_risk(t1, r_left0) : t1;
    assign t3 = f3 ? add_risk(t2, r_height) : t2;

    always_comb begin
        e1 = '{row: r_pos.row - 7'd1, col: r_pos.col, height: above, total: t1};
        e2 = '{row: r_pos.row, col: r_pos.col - 7'd1, height: r_left0, total: t2};
        e3 = '{row: r_pos.row, col: r_pos.col, height: r_height, total: t3};
        // pack the flagged candidates from slot 0
        set.num     = 2'(f1) + 2'(f2) + 2'(f3);
        set.slot[0] = f1 ? e1 : (f2 ? e2 : e3);
        set.slot[1] = (f1 && f2) ? e2 : e3;
        set.slot[2] = e3;
    end

    assign o_advance = r_valid && ((set.num == 2'd0) || i_q_free);
    assign o_ready   = !r_valid || o_advance;
    assign o_q_load  = o_advance && (set.num != 2'd0);
    assign o_set     = set;
    assign o_wr_data = {above, r_height};

    // stage valid and row context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_left0      <= 4'd0;
            r_left1      <= 4'd0;
            r_left_above <= 4'd0;
            r_risk_sum   <= 18'd0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
            end else if (o_advance) begin
                r_valid <= 1'b0;
            end
            if (i_clear) begin
                r_left0    <= 4'd0;
                r_left1    <= 4'd0;
                r_risk_sum <= 18'd0;
            end else if (o_advance) begin
                r_left_above <= above;
                r_risk_sum   <= (r_pos.row_last && r_pos.col_last) ? 18'd0 : t3;
                if (r_pos.col_last) begin
                    r_left0 <= 4'd0;
                    r_left1 <= 4'd0;
                end else begin
                    r_left0 <= r_height;
                    r_left1 <= r_left0;
                end
            end
        end
    end

    // item payload, heights above nine count as nine
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_height <= (i_height > HEIGHT_MAX) ? HEIGHT_MAX : i_height;
            r_pos    <= i_pos;
        end
    end

endmodule

/* design/glm_out_queue.sv */
// result buffer that hands out up to three low cells of one item in order
module glm_out_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  glm_pkg::t_result_set i_set,
    input  logic                 i_stall,
    output logic                 o_free,
    output logic                 o_valid,
    output logic [6:0]           o_low_row,
    output logic [6:0]           o_low_col,
    output logic [3:0]           o_low_height,
    output logic [3:0]           o_low_risk,
    output logic [17:0]          o_risk_total,
    output logic                 o_last_of_run
);
    import glm_pkg::*;

    t_result_set r_set;
    logic [1:0]  r_idx;
    t_result     cur;
    logic        last;
    logic        out_acc;

    assign cur     = r_set.slot[r_idx];
    assign o_valid = (r_set.num != 2'd0);
    assign last    = (r_idx == (r_set.num - 2'd1));
    assign out_acc = o_valid && !i_stall;
    assign o_free  = !o_valid || (out_acc && last);

    // count, index and slots of the results on offer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set.num <= 2'd0;
            r_idx     <= 2'd0;
        end else if (i_load) begin
            r_set     <= i_set;
            r_idx     <= 2'd0;
        end else if (out_acc) begin
            if (last) begin
                r_set.num <= 2'd0;
                r_idx     <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_low_row     = cur.row;
    assign o_low_col     = cur.col;
    assign o_low_height  = cur.height;
    assign o_low_risk    = cur.height + 4'd1;
    assign o_risk_total  = cur.total;
    assign o_last_of_run = last;

endmodule

/* design/grid_local_minimum_detector_unit.sv */
// top level of the grid local minimum detector
// path: an accepted item is registered into the judge stage, its low cells then into the result buffer
// throughput: one cell per cycle while the sink does not stall; an item releasing several
// low cells holds the result port until all are taken; the line buffer is read at accept
// reset: synchronous, clears counters, risk sum, neighbor registers and pending results,
// grid size back to 100 by 100; line buffer words are rewritten before they are used
`include "assert_macros.svh"

module grid_local_minimum_detector_unit #(
    parameter int MAX_COLS = glm_pkg::GLM_MAX_COLS,
    parameter int MAX_ROWS = glm_pkg::GLM_MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // cell input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_cell_height,
    // low cell output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_low_row,
    output logic [6:0]  o_low_col,
    output logic [3:0]  o_low_height,
    output logic [3:0]  o_low_risk,
    output logic [17:0] o_risk_total,
    output logic        o_last_of_run
);
    import glm_pkg::*;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CSZ_W = ($clog2(MAX_COLS + 1) > 8) ? $clog2(MAX_COLS + 1) : 8;
    localparam int RSZ_W = ($clog2(MAX_ROWS + 1) > 8) ? $clog2(MAX_ROWS + 1) : 8;

    logic [7:0]       r_grid_cols;
    logic [7:0]       r_grid_rows;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             cfg_wr;
    t_reg_idx         reg_idx;
    logic [CSZ_W-1:0] cols_ext;
    logic [RSZ_W-1:0] rows_ext;
    logic [CSZ_W-1:0] cols_eff;
    logic [RSZ_W-1:0] rows_eff;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic [COL_W-1:0] next_addr;
    logic             in_acc;
    t_pos             pos;

    logic             s1_ready;
    logic             s1_advance;
    logic [7:0]       wr_data;
    logic [7:0]       cur_word;
    logic [7:0]       next_word;
    logic             q_load;
    logic             q_free;
    t_result_set      res_set;
    logic             run_done;

    // configuration registers
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_DEFAULT;
            r_grid_rows <= GRID_DEFAULT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GRID_COLS: r_grid_cols <= pwdata[7:0];
                REG_GRID_ROWS: r_grid_rows <= pwdata[7:0];
                default:       r_grid_cols <= r_grid_cols;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_COLS: prdata = {24'd0, r_grid_cols};
            REG_GRID_ROWS: prdata = {24'd0, r_grid_rows};
            default:       prdata = 32'd0;
        endcase
    end

    // effective grid size, zero acts as one and large values clamp
    assign cols_ext = CSZ_W'(r_grid_cols);
    assign rows_ext = RSZ_W'(r_grid_rows);

    always_comb begin
        if (cols_ext == '0) begin
            cols_eff = CSZ_W'(1);
        end else if (cols_ext > CSZ_W'(MAX_COLS)) begin
            cols_eff = CSZ_W'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
        if (rows_ext == '0) begin
            rows_eff = RSZ_W'(1);
        end else if (rows_ext > RSZ_W'(MAX_ROWS)) begin
            rows_eff = RSZ_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
    end

    assign col_last = COL_W'(cols_eff - CSZ_W'(1));
    assign row_last = ROW_W'(rows_eff - RSZ_W'(1));

    // input handshake
    assign o_stall = !s1_ready;
    assign in_acc  = i_valid && s1_ready;

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (r_col == col_last) begin
                r_col <= '0;
                r_row <= (r_row == row_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // position flags of the accepted item
    always_comb begin
        pos.row      = 7'(r_row);
        pos.col      = 7'(r_col);
        pos.row_ge1  = (r_row != '0);
        pos.row_ge2  = (r_row > ROW_W'(1));
        pos.col_ge1  = (r_col != '0);
        pos.col_ge2  = (r_col > COL_W'(1));
        pos.row_last = (r_row == row_last);
        pos.col_last = (r_col == col_last);
    end

    // right neighbor column, held on the current one at the row end
    assign next_addr = (r_col == col_last) ? r_col : r_col + COL_W'(1);

    glm_line_buf #(
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_rd_en     (in_acc),
        .i_addr      (r_col),
        .i_next_addr (next_addr),
        .i_wr_en     (s1_advance),
        .i_wr_data   (wr_data),
        .o_cur_word  (cur_word),
        .o_next_word (next_word)
    );

    glm_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_wr),
        .i_load      (in_acc),
        .i_height    (i_cell_height),
        .i_pos       (pos),
        .i_cur_word  (cur_word),
        .i_next_word (next_word),
        .i_q_free    (q_free),
        .o_ready     (s1_ready),
        .o_advance   (s1_advance),
        .o_wr_data   (wr_data),
        .o_q_load    (q_load),
        .o_set       (res_set)
    );

    glm_out_queue u_out_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (q_load),
        .i_set         (res_set),
        .i_stall       (i_stall),
        .o_free        (q_free),
        .o_valid       (o_valid),
        .o_low_row     (o_low_row),
        .o_low_col     (o_low_col),
        .o_low_height  (o_low_height),
        .o_low_risk    (o_low_risk),
        .o_risk_total  (o_risk_total),
        .o_last_of_run (o_last_of_run)
    );

    // final result of a run taken by the sink
    assign run_done = o_valid && !i_stall && o_last_of_run;

    // checks
    `GLM_ASSERT_ALWAYS(a_col_range, r_col <= col_last, "column counter beyond grid width")
    `GLM_ASSERT_ALWAYS(a_row_range, r_row <= row_last, "row counter beyond grid height")
    `GLM_ASSERT_NEXT(a_q_load_shows, q_load, o_valid, "loaded results not offered")
    `GLM_ASSERT_NEXT(a_run_ends, run_done && !q_load, !o_valid, "result offered past its run")

endmodule
